>>> hdl/npps_pkg.sv
// ----------------------------------------------------------------------------
// npps_pkg: shared types and constants for the priority scheduler
// Field widths, the stored job record, the write port record and the engine
// state encoding.
// ----------------------------------------------------------------------------
package npps_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam int ID_W       = 8;
   localparam int TICK_W     = 16;
   localparam int PRIO_W     = 8;
   localparam int FINISH_W   = 23;
   localparam int SLOT_OUT_W = 6;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] arrival;
      logic [TICK_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
   } job_type;

   // job store write from the front end
   typedef struct packed {
      logic    en;
      job_type job;
   } job_wr_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_LAST,
      ENG_DECIDE
   } eng_state_type;

endpackage

>>> hdl/npps_queue.sv
// ----------------------------------------------------------------------------
// npps_queue: two-entry batch queue
// Holds batch descriptors (bank, job count) between the loader and the
// scheduling engine.
// ----------------------------------------------------------------------------
module npps_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

>>> hdl/npps_front.sv
// ----------------------------------------------------------------------------
// npps_front: job loader
// Accepts jobs, writes them into the free bank of the job store and queues a
// batch descriptor when the last job of a batch arrives.
// ----------------------------------------------------------------------------
module npps_front
   import npps_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   localparam int SLOT_W = $clog2(MAX_ENTRIES),
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [ID_W-1:0]   req_job_id,
   input  logic [TICK_W-1:0] req_arrival,
   input  logic [TICK_W-1:0] req_burst,
   input  logic [PRIO_W-1:0] req_prio,
   input  logic              req_batch_end,
   output job_wr_type        wr,
   output logic [SLOT_W:0]   wr_addr,
   output logic              push,
   output logic [CNT_W:0]    push_data,
   input  logic              batch_done
);

   logic             accept;
   logic             has_room;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             bank_ff, bank_in;
   logic [1:0]       occ_ff, occ_in;
   logic [CNT_W-1:0] batch_len;

   assign busy     = (occ_ff == 2'd2);
   assign accept   = start && !busy;
   assign has_room = (cnt_ff < CNT_W'(MAX_ENTRIES));

   always_comb begin
      batch_len = has_room ? (cnt_ff + CNT_W'(1)) : CNT_W'(MAX_ENTRIES);
      push      = accept && req_batch_end;
      push_data = {bank_ff, batch_len};

      wr.en          = accept && has_room;
      wr.job.id      = req_job_id;
      wr.job.arrival = req_arrival;
      wr.job.burst   = req_burst;
      wr.job.prio    = req_prio;
      wr_addr        = {bank_ff, cnt_ff[SLOT_W-1:0]};

      // a finished batch closes the bank; the next job opens the other one
      cnt_in  = cnt_ff;
      bank_in = bank_ff;
      if (push) begin
         cnt_in  = '0;
         bank_in = !bank_ff;
      end else if (wr.en) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      occ_in = occ_ff + {1'b0, push} - {1'b0, batch_done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         bank_ff <= 1'b0;
         occ_ff  <= 2'd0;
      end else begin
         cnt_ff  <= cnt_in;
         bank_ff <= bank_in;
         occ_ff  <= occ_in;
      end
   end

endmodule

>>> hdl/npps_engine.sv
// ----------------------------------------------------------------------------
// npps_engine: scheduling engine
// Owns the two-bank job store. Per decision it scans the batch one entry a
// cycle, then runs the best ready job or jumps time to the next arrival.
// ----------------------------------------------------------------------------
module npps_engine
   import npps_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   localparam int SLOT_W = $clog2(MAX_ENTRIES),
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1),
   localparam int DEPTH  = 2 ** (SLOT_W + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  job_wr_type            wr,
   input  logic [SLOT_W:0]       wr_addr,
   input  logic                  q_valid,
   input  logic [CNT_W:0]        q_data,
   output logic                  pop,
   output logic                  batch_done,
   output logic                  rsp_strobe,
   output logic [ID_W-1:0]       rsp_done_id,
   output logic [SLOT_OUT_W-1:0] rsp_done_slot,
   output logic [FINISH_W-1:0]   rsp_finish_time,
   output logic                  rsp_final_result
);

   job_type mem_ff [DEPTH];

   eng_state_type state_ff, state_in;

   logic                   bank_ff, bank_in;
   logic [CNT_W-1:0]       num_ff, num_in;
   logic [CNT_W-1:0]       done_cnt_ff, done_cnt_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   rd_vld_ff;
   logic [SLOT_W-1:0]      rd_slot_ff;
   job_type                rd_data_ff;
   logic [FINISH_W-1:0]    time_ff, time_in;
   logic [MAX_ENTRIES-1:0] fin_mask_ff, fin_mask_in;
   logic                   found_ff, found_in;
   job_type                best_ff, best_in;
   logic [SLOT_W-1:0]      best_slot_ff, best_slot_in;
   logic [TICK_W-1:0]      min_arr_ff, min_arr_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [FINISH_W-1:0]   rsp_time_ff;
   logic                  rsp_final_ff;

   logic                is_last;
   logic                rd_pending;
   logic                rd_ready;
   logic                rd_better;
   logic [FINISH_W-1:0] finish;

   // store: front end writes one bank, engine reads the other
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.job;
      end
      rd_data_ff <= mem_ff[{bank_ff, idx_ff[SLOT_W-1:0]}];
      rd_slot_ff <= idx_ff[SLOT_W-1:0];
   end

   assign is_last    = (done_cnt_ff + CNT_W'(1) == num_ff);
   assign finish     = time_ff + FINISH_W'(best_ff.burst);
   assign rd_pending = rd_vld_ff && !fin_mask_ff[rd_slot_ff];
   assign rd_ready   = rd_pending && (FINISH_W'(rd_data_ff.arrival) <= time_ff);
   assign rd_better  = !found_ff ||
                       ({rd_data_ff.prio, rd_data_ff.arrival, rd_data_ff.id} <
                        {best_ff.prio, best_ff.arrival, best_ff.id});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (q_valid) begin
               state_in = ENG_SCAN;
            end
         end
         ENG_SCAN: begin
            if (idx_ff + CNT_W'(1) == num_ff) begin
               state_in = ENG_LAST;
            end
         end
         ENG_LAST: begin
            state_in = ENG_DECIDE;
         end
         ENG_DECIDE: begin
            state_in = (found_ff && is_last) ? ENG_IDLE : ENG_SCAN;
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop           = 1'b0;
      batch_done    = 1'b0;
      rsp_strobe_in = 1'b0;
      bank_in       = bank_ff;
      num_in        = num_ff;
      done_cnt_in   = done_cnt_ff;
      idx_in        = idx_ff;
      time_in       = time_ff;
      fin_mask_in   = fin_mask_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_slot_in  = best_slot_ff;
      min_arr_in    = min_arr_ff;

      // fold the returning entry into the running best and earliest arrival
      if (rd_ready && rd_better) begin
         found_in     = 1'b1;
         best_in      = rd_data_ff;
         best_slot_in = rd_slot_ff;
      end
      if (rd_pending && (rd_data_ff.arrival < min_arr_ff)) begin
         min_arr_in = rd_data_ff.arrival;
      end

      case (state_ff)
         ENG_IDLE: begin
            if (q_valid) begin
               pop         = 1'b1;
               bank_in     = q_data[CNT_W];
               num_in      = q_data[CNT_W-1:0];
               done_cnt_in = '0;
               time_in     = '0;
               fin_mask_in = '0;
               idx_in      = '0;
               found_in    = 1'b0;
               min_arr_in  = '1;
            end
         end
         ENG_SCAN: begin
            idx_in = idx_ff + CNT_W'(1);
         end
         ENG_LAST: begin
         end
         ENG_DECIDE: begin
            if (found_ff) begin
               time_in                   = finish;
               fin_mask_in[best_slot_ff] = 1'b1;
               done_cnt_in               = done_cnt_ff + CNT_W'(1);
               rsp_strobe_in             = 1'b1;
               batch_done                = is_last;
            end else begin
               time_in = FINISH_W'(min_arr_ff);
            end
            idx_in     = '0;
            found_in   = 1'b0;
            min_arr_in = '1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ENG_IDLE;
         rsp_strobe_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         bank_ff       <= 1'b0;
         num_ff        <= '0;
         done_cnt_ff   <= '0;
         idx_ff        <= '0;
         time_ff       <= '0;
         fin_mask_ff   <= '0;
         found_ff      <= 1'b0;
         min_arr_ff    <= '1;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rd_vld_ff     <= (state_ff == ENG_SCAN);
         bank_ff       <= bank_in;
         num_ff        <= num_in;
         done_cnt_ff   <= done_cnt_in;
         idx_ff        <= idx_in;
         time_ff       <= time_in;
         fin_mask_ff   <= fin_mask_in;
         found_ff      <= found_in;
         min_arr_ff    <= min_arr_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      if (rsp_strobe_in) begin
         rsp_id_ff    <= best_ff.id;
         rsp_slot_ff  <= SLOT_OUT_W'(best_slot_ff);
         rsp_time_ff  <= finish;
         rsp_final_ff <= is_last;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_done_id      = rsp_id_ff;
   assign rsp_done_slot    = rsp_slot_ff;
   assign rsp_finish_time  = rsp_time_ff;
   assign rsp_final_result = rsp_final_ff;

   // a decision always follows a full scan, so results never come back to back
   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("results issued in consecutive cycles");

   // an idle decision must move time forward
   a_idle_jump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_DECIDE && !found_ff) |-> (FINISH_W'(min_arr_ff) > time_ff))
      else $error("idle jump does not advance time");

   // the chosen job has not run yet
   a_pick_unfinished: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_DECIDE && found_ff) |-> !fin_mask_ff[best_slot_ff])
      else $error("finished job picked again");

   // completions stay below the batch size while a batch is active
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ENG_IDLE) |-> (done_cnt_ff < num_ff))
      else $error("completion count overran batch");

endmodule

>>> hdl/nonpreemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core: non-preemptive priority scheduler
// Loads batches of jobs and emits their completion times in execution order.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_* with start high; a job transfers at a clock edge with
//   start high and busy low, one job per cycle. req_batch_end marks the last
//   job of a batch; jobs past MAX_ENTRIES in a batch are dropped, but a
//   batch_end on a dropped job still closes the batch.
//   Output: one result per job, held on rsp_* for a single cycle with
//   rsp_strobe high; rsp_final_result flags the last job of the batch. The
//   receiver cannot stall, so results must be taken as they appear.
//   Timing: the job store has two banks. While the engine schedules one
//   batch the loader fills the other; busy rises only when both banks hold
//   closed batches. Each decision scans the batch one entry a cycle through
//   the store's read port; an idle time jump costs one extra decision, so a
//   batch takes at most two decisions per job.
//   Reset: clears the counters, queue and engine; the store needs no clear.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_core
   import npps_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ID_W-1:0]       req_job_id,
   input  logic [TICK_W-1:0]     req_arrival,
   input  logic [TICK_W-1:0]     req_burst,
   input  logic [PRIO_W-1:0]     req_prio,
   input  logic                  req_batch_end,
   output logic                  rsp_strobe,
   output logic [ID_W-1:0]       rsp_done_id,
   output logic [SLOT_OUT_W-1:0] rsp_done_slot,
   output logic [FINISH_W-1:0]   rsp_finish_time,
   output logic                  rsp_final_result
);

   localparam int SLOT_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

   job_wr_type       wr;
   logic [SLOT_W:0]  wr_addr;
   logic             push;
   logic [CNT_W:0]   push_data;
   logic             pop;
   logic             q_valid;
   logic [CNT_W:0]   q_data;
   logic             batch_done;

   // loader: store jobs, close batches
   npps_front #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_job_id    (req_job_id),
      .req_arrival   (req_arrival),
      .req_burst     (req_burst),
      .req_prio      (req_prio),
      .req_batch_end (req_batch_end),
      .wr            (wr),
      .wr_addr       (wr_addr),
      .push          (push),
      .push_data     (push_data),
      .batch_done    (batch_done)
   );

   // hold closed batches until the engine picks them up
   npps_queue #(
      .DATA_W(CNT_W + 1)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   // engine: scan, pick, run, report
   npps_engine #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .wr_addr          (wr_addr),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .pop              (pop),
      .batch_done       (batch_done),
      .rsp_strobe       (rsp_strobe),
      .rsp_done_id      (rsp_done_id),
      .rsp_done_slot    (rsp_done_slot),
      .rsp_finish_time  (rsp_finish_time),
      .rsp_final_result (rsp_final_result)
   );

endmodule

>>> tb/tb_nonpreemptive_priority_scheduler_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler_core: self-checking bench for the core
// Sends batches of jobs through the command port and computes each batch's
// non-preemptive priority schedule in the bench. Every completion strobe is
// checked, field by field and in order, against the predicted completion.
// Both the sender gaps and the batch shapes are random. Results cannot be
// stalled.
// ----------------------------------------------------------------------------
module tb_nonpreemptive_priority_scheduler_core;
   import npps_pkg::*;

   localparam int DEPTH        = MAX_ENTRIES_DEF;
   localparam int RANDOM_JOBS  = 140;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   // one job as queued for the driver: payload, batch close flag, idle after
   typedef struct {
      job_type job;
      logic    closes;
      int      gap;
   } job_req_type;

   // one completion as the core should report it
   typedef struct {
      logic [ID_W-1:0]       id;
      logic [SLOT_OUT_W-1:0] slot;
      logic [FINISH_W-1:0]   finish;
      logic                  last;
   } completion_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [ID_W-1:0]       req_job_id    = '0;
   logic [TICK_W-1:0]     req_arrival   = '0;
   logic [TICK_W-1:0]     req_burst     = '0;
   logic [PRIO_W-1:0]     req_prio      = '0;
   logic                  req_batch_end = 1'b0;
   logic                  rsp_strobe;
   logic [ID_W-1:0]       rsp_done_id;
   logic [SLOT_OUT_W-1:0] rsp_done_slot;
   logic [FINISH_W-1:0]   rsp_finish_time;
   logic                  rsp_final_result;

   job_req_type    pending_jobs[$];
   completion_type completions_due[$];

   // bench copy of the job store
   job_type slot_jobs[DEPTH];
   int      slot_count = 0;

   logic job_taken = 1'b0;
   int   gap_left  = 0;
   int   fail_count = 0;
   int   cycle_count = 0;

   nonpreemptive_priority_scheduler_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_job_id       (req_job_id),
      .req_arrival      (req_arrival),
      .req_burst        (req_burst),
      .req_prio         (req_prio),
      .req_batch_end    (req_batch_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_done_id      (rsp_done_id),
      .rsp_done_slot    (rsp_done_slot),
      .rsp_finish_time  (rsp_finish_time),
      .rsp_final_result (rsp_final_result)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Scheduler prediction
   // ------------------------------------------------------------------------

   // True when slot a goes ahead of slot b: lower prio number, then earlier
   // arrival, then smaller id, then lower slot.
   function automatic bit runs_first(int a, int b);
      if (slot_jobs[a].prio != slot_jobs[b].prio)
         return slot_jobs[a].prio < slot_jobs[b].prio;
      if (slot_jobs[a].arrival != slot_jobs[b].arrival)
         return slot_jobs[a].arrival < slot_jobs[b].arrival;
      if (slot_jobs[a].id != slot_jobs[b].id)
         return slot_jobs[a].id < slot_jobs[b].id;
      return a < b;
   endfunction

   // Run the stored batch from time zero and queue one completion per job in
   // execution order. Empty the store for the next batch.
   task automatic schedule_batch();
      bit [DEPTH-1:0]      finished;
      logic [FINISH_W-1:0] sched_time;
      int unsigned         earliest_arr;
      int                  emitted;
      int                  best;
      bit                  found;
      completion_type      c;
      finished   = '0;
      sched_time = '0;
      emitted    = 0;
      while (emitted < slot_count) begin
         found = 1'b0;
         best  = 0;
         for (int i = 0; i < slot_count; i++) begin
            if (finished[i]) continue;
            if (slot_jobs[i].arrival > sched_time) continue;
            if (!found || runs_first(i, best)) begin
               best  = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            // nothing ready: jump to the earliest pending arrival
            earliest_arr = 32'hFFFF_FFFF;
            for (int i = 0; i < slot_count; i++) begin
               if (!finished[i] && slot_jobs[i].arrival < earliest_arr)
                  earliest_arr = 32'(slot_jobs[i].arrival);
            end
            sched_time = FINISH_W'(earliest_arr);
            continue;
         end
         sched_time     = sched_time + FINISH_W'(slot_jobs[best].burst);
         finished[best] = 1'b1;
         c.id     = slot_jobs[best].id;
         c.slot   = SLOT_OUT_W'(best);
         c.finish = sched_time;
         c.last   = (emitted + 1 == slot_count);
         completions_due.push_back(c);
         emitted++;
      end
      slot_count = 0;
   endtask

   // Store one transferred job; drop it if the store is full. A batch end
   // closes the batch whether or not its job was stored.
   task automatic take_job(job_type j, logic closes);
      if (slot_count < DEPTH) begin
         slot_jobs[slot_count] = j;
         slot_count++;
      end
      if (closes) schedule_batch();
   endtask

   // ------------------------------------------------------------------------
   // Driver: present jobs at the falling edge, advance after each transfer
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      job_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || job_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_jobs.size() > 0) begin
            nxt = pending_jobs.pop_front();
            req_job_id    <= nxt.job.id;
            req_arrival   <= nxt.job.arrival;
            req_burst     <= nxt.job.burst;
            req_prio      <= nxt.job.prio;
            req_batch_end <= nxt.closes;
            start         <= 1'b1;
            gap_left      <= nxt.gap;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ------------------------------------------------------------------------
   task automatic check_completion();
      completion_type want;
      if (completions_due.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("%0t: unexpected result id=%0d slot=%0d finish=%0d last=%0b",
                     $realtime, rsp_done_id, rsp_done_slot, rsp_finish_time,
                     rsp_final_result);
         return;
      end
      want = completions_due.pop_front();
      if (rsp_done_id !== want.id || rsp_done_slot !== want.slot ||
          rsp_finish_time !== want.finish || rsp_final_result !== want.last) begin
         fail_count++;
         if (fail_count <= REPORT_MAX) begin
            $write("%0t: mismatch exp id=%0d slot=%0d finish=%0d last=%0b,",
                   $realtime, want.id, want.slot, want.finish, want.last);
            $display(" got id=%0d slot=%0d finish=%0d last=%0b",
                     rsp_done_id, rsp_done_slot, rsp_finish_time, rsp_final_result);
         end
      end
   endtask

   always @(posedge clock) begin
      job_type j;
      if (reset) begin
         job_taken <= 1'b0;
      end else begin
         job_taken <= start && !busy;
         // check first: a new batch only appends behind what is already due
         if (rsp_strobe) check_completion();
         if (start && !busy) begin
            j.id      = req_job_id;
            j.arrival = req_arrival;
            j.burst   = req_burst;
            j.prio    = req_prio;
            take_job(j, req_batch_end);
         end
      end
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_nonpreemptive_priority_scheduler_core: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_job(int id, int arrival, int burst, int prio, bit closes,
                            bit quiet);
      job_req_type r;
      r.job.id      = ID_W'(id);
      r.job.arrival = TICK_W'(arrival);
      r.job.burst   = TICK_W'(burst);
      r.job.prio    = PRIO_W'(prio);
      r.closes      = closes;
      r.gap         = pick_gap(quiet);
      pending_jobs.push_back(r);
   endtask

   initial begin
      int  sent;
      int  batch_len;
      int  shape;
      int  prio_mode, arr_mode, burst_mode, id_mode;
      int  id, arrival, burst, prio;
      bit  quiet;

      // single job at the low extreme of every field
      queue_job(0, 0, 0, 0, 1'b1, 1'b0);
      // single job at the high extreme: idle jump to 65535, then max burst
      queue_job(255, 65535, 65535, 255, 1'b1, 1'b0);

      // full batch: priority, arrival, id and slot tie-breaks, a zero burst,
      // idle jumps, max bursts, then two jobs dropped on a full store with
      // the second one closing the batch
      queue_job(9, 100, 5, 2, 1'b0, 1'b1);
      queue_job(3, 0, 10, 7, 1'b0, 1'b1);
      queue_job(3, 0, 0, 7, 1'b0, 1'b1);
      queue_job(1, 0, 20, 7, 1'b0, 1'b1);
      queue_job(200, 5, 3, 0, 1'b0, 1'b0);
      queue_job(4, 2, 7, 7, 1'b0, 1'b0);
      queue_job(250, 60000, 65535, 255, 1'b0, 1'b0);
      queue_job(0, 65535, 65535, 0, 1'b0, 1'b0);
      for (int i = 0; i < 8; i++)
         queue_job(16 + i, 65535 - i, 65535, i * 16, 1'b0, 1'b0);
      queue_job(77, 1, 1, 0, 1'b0, 1'b0);
      queue_job(78, 0, 0, 0, 1'b1, 1'b0);

      // random batches: mostly well-formed, some overfull, mixed field ranges
      sent = 0;
      while (sent < RANDOM_JOBS) begin
         shape = $urandom_range(0, 9);
         if (shape == 0)      batch_len = 1;
         else if (shape == 1) batch_len = DEPTH;
         else if (shape == 2) batch_len = $urandom_range(DEPTH + 1, DEPTH + 3);
         else                 batch_len = $urandom_range(2, DEPTH);
         prio_mode  = $urandom_range(0, 1);
         arr_mode   = $urandom_range(0, 2);
         burst_mode = $urandom_range(0, 1);
         id_mode    = $urandom_range(0, 1);
         quiet      = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < batch_len; i++) begin
            id      = id_mode    ? $urandom_range(0, 255)   : $urandom_range(0, 3);
            prio    = prio_mode  ? $urandom_range(0, 255)   : $urandom_range(0, 3);
            burst   = burst_mode ? $urandom_range(0, 65535) : $urandom_range(0, 20);
            case (arr_mode)
               0: arrival = $urandom_range(0, 15);
               1: arrival = $urandom_range(0, 65535);
               default: arrival = i * $urandom_range(0, 200);
            endcase
            queue_job(id, arrival, burst, prio, i == batch_len - 1, quiet);
         end
         sent += batch_len;
      end

      // hold reset, then release it at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until every job has transferred and every completion arrived
      while (pending_jobs.size() != 0 || start || completions_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (completions_due.size() != 0)
         $display("%0d completions never arrived", completions_due.size());
      if (fail_count == 0 && completions_due.size() == 0) begin
         $display("tb_nonpreemptive_priority_scheduler_core: PASS");
      end else begin
         $display("tb_nonpreemptive_priority_scheduler_core: FAIL");
      end
      $finish;
   end

endmodule
